FILE: src/integer_to_ascii_radix_assert.svh
// Assertion macros used by the integer_to_ascii_radix controller (itoa_ctrl).
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed");

// Next-cycle implication, checked outside reset.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed");

`endif

FILE: src/itoa_pkg.sv
// Shared constants, types and digit encoding for the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;
    localparam int DIGIT_W         = 6;
    localparam int STEP_BITS       = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS   = 7'h2D;
    localparam logic [DIGIT_W-1:0] DEC_MAX_DIGIT = 6'd9;
    localparam logic [CHAR_W-1:0]  DEC_DIGITS    = 7'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic digit_end;
        logic wr_en;
        logic rd_en;
        logic emit_minus;
    } cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic neg;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d > DEC_MAX_DIGIT)
        begin
            ch = ASCII_A_LOWER + CHAR_W'(d) - DEC_DIGITS;
        end
        else
        begin
            ch = ASCII_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

FILE: src/itoa_ctrl.sv
// Controller: sequences digit division, sign output and digit readout.
`include "integer_to_ascii_radix_assert.svh"

module itoa_ctrl #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           valid,
    output logic                           last,
    output itoa_pkg::cmd_t                 cmd,
    input  itoa_pkg::status_t              status,
    output logic [$clog2(VALUE_WIDTH)-1:0] mem_addr
);

    localparam int DIV_STEPS = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int SW = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] nd_reg, nd_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic          last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            nd_reg    <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            nd_reg    <= nd_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        nd_next    = nd_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        cmd        = '0;
        mem_addr   = nd_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    nd_next    = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (step_reg == SW'(DIV_STEPS - 1))
                begin
                    cmd.digit_end = 1'b1;
                    cmd.wr_en     = (nd_reg < CW'(VALUE_WIDTH));
                    step_next     = '0;
                    if (nd_reg < CW'(VALUE_WIDTH))
                    begin
                        nd_next = nd_reg + CW'(1);
                    end
                    if (status.quot_zero)
                    begin
                        idx_next   = nd_reg[AW-1:0];
                        state_next = status.neg ? ST_SIGN : ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_SIGN:
            begin
                cmd.emit_minus = 1'b1;
                valid_next     = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.rd_en  = 1'b1;
                mem_addr   = idx_reg;
                valid_next = 1'b1;
                last_next  = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign last  = last_reg;

    `ITOA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ITOA_ASSERT_NEXT(a_last_gap, clk, rst_n, valid_reg && last_reg, !valid_reg)
    `ITOA_ASSERT_NOW(a_emit_idx, clk, rst_n, state_reg == ST_EMIT, CW'(idx_reg) < nd_reg)

endmodule

FILE: src/itoa_dp.sv
// Datapath: radix clamp, sign handling, shared digit divider and digit store.
module itoa_dp #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [itoa_pkg::IN_VALUE_W-1:0]     value,
    input  logic [itoa_pkg::RADIX_W-1:0]        radix,
    input  logic                                signed_mode,
    input  itoa_pkg::cmd_t                      cmd,
    output itoa_pkg::status_t                   status,
    input  logic [$clog2(VALUE_WIDTH)-1:0]      mem_addr,
    output logic [itoa_pkg::CHAR_W-1:0]         character
);

    localparam int DIV_STEPS = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
    localparam int PAD_W     = DIV_STEPS * itoa_pkg::STEP_BITS;
    localparam int RW        = itoa_pkg::RADIX_W + 1;
    localparam int DW        = itoa_pkg::DIGIT_W;

    logic [PAD_W-1:0]                 dq_reg;
    logic [DW-1:0]                    rem_reg;
    logic [itoa_pkg::RADIX_W-1:0]     radix_reg;
    logic                             neg_reg;
    logic [DW-1:0]                    rd_data_reg;
    logic                             minus_reg;
    logic [DW-1:0]                    mem [VALUE_WIDTH];

    logic [VALUE_WIDTH+itoa_pkg::IN_VALUE_W-1:0] value_ext;
    logic [VALUE_WIDTH-1:0]           value_w;
    logic                             neg_in;
    logic [VALUE_WIDTH-1:0]           mag;
    logic [itoa_pkg::RADIX_W-1:0]     radix_clamped;
    logic [RW-1:0]                    step_rem;
    logic [PAD_W-1:0]                 step_quot;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
    assign value_w   = value_ext[VALUE_WIDTH-1:0];
    assign neg_in    = signed_mode & value_w[VALUE_WIDTH-1];
    assign mag       = neg_in ? (~value_w + VALUE_WIDTH'(1)) : value_w;

    always_comb
    begin
        if (radix < itoa_pkg::RADIX_MIN)
        begin
            radix_clamped = itoa_pkg::RADIX_MIN;
        end
        else if (radix > itoa_pkg::RADIX_MAX)
        begin
            radix_clamped = itoa_pkg::RADIX_MAX;
        end
        else
        begin
            radix_clamped = radix;
        end
    end

    always_comb
    begin
        step_rem  = RW'(rem_reg);
        step_quot = dq_reg;
        for (int i = 0; i < itoa_pkg::STEP_BITS; i++)
        begin
            step_rem  = {step_rem[RW-2:0], step_quot[PAD_W-1]};
            step_quot = {step_quot[PAD_W-2:0], 1'b0};
            if (step_rem >= RW'(radix_reg))
            begin
                step_rem     = step_rem - RW'(radix_reg);
                step_quot[0] = 1'b1;
            end
        end
    end

    assign status.quot_zero = (step_quot == '0);
    assign status.neg       = neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg   <= 1'b0;
            radix_reg <= itoa_pkg::RADIX_MIN;
        end
        else if (cmd.load)
        begin
            neg_reg   <= neg_in;
            radix_reg <= radix_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dq_reg  <= PAD_W'(mag);
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            dq_reg  <= step_quot;
            rem_reg <= cmd.digit_end ? '0 : step_rem[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[mem_addr] <= step_rem[DW-1:0];
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            minus_reg <= 1'b0;
        end
        else if (cmd.emit_minus)
        begin
            minus_reg <= 1'b1;
        end
    end

    assign character = minus_reg ? itoa_pkg::ASCII_MINUS : itoa_pkg::digit_char(rd_data_reg);

endmodule

FILE: src/integer_to_ascii_radix.sv
// Top level: converts one number per item into ASCII digits in radix 2..36.
// Each digit comes from a full pass of the shared 4-bit-per-cycle divider over the value.
// For D digits, the first character (the minus, if any) shows once all D digits are divided.
// Characters then stream one per cycle with no stall from the receiver; busy drops as the
// last one shows, and a new start is taken only once busy is low.
// rst_n clears the controller asynchronously; the digit store needs no clearing.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [itoa_pkg::IN_VALUE_W-1:0] value,
    input  logic [itoa_pkg::RADIX_W-1:0]    radix,
    input  logic                            signed_mode,
    output logic                            valid,
    output logic [itoa_pkg::CHAR_W-1:0]     character,
    output logic                            last
);

    itoa_pkg::cmd_t                 cmd;
    itoa_pkg::status_t              status;
    logic [$clog2(VALUE_WIDTH)-1:0] mem_addr;

    itoa_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .valid    (valid),
        .last     (last),
        .cmd      (cmd),
        .status   (status),
        .mem_addr (mem_addr)
    );

    itoa_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .radix       (radix),
        .signed_mode (signed_mode),
        .cmd         (cmd),
        .status      (status),
        .mem_addr    (mem_addr),
        .character   (character)
    );

endmodule
